@@ hdl/stip_pkg.sv @@
package stip_pkg;

   // field widths
   localparam int CH_W         = 8;
   localparam int RADIX_W      = 6;
   localparam int VALUE_W      = 64;
   localparam int END_OFFSET_W = 16;
   localparam int STATUS_W     = 2;

   // width of the internal character counters (saturating)
   localparam int OFFSET_BITS  = 16;

   // configuration port
   localparam int CSR_INDEX_W  = 1;
   localparam int CSR_DATA_W   = RADIX_W;

   localparam logic [CSR_INDEX_W-1:0] REG_RADIX       = 1'b0;
   localparam logic [CSR_INDEX_W-1:0] REG_SIGNED_MODE = 1'b1;

   localparam logic [RADIX_W-1:0] RADIX_RESET  = 6'd10;
   localparam logic [RADIX_W-1:0] RADIX_MIN    = 6'd2;
   localparam logic [RADIX_W-1:0] RADIX_MAX    = 6'd36;
   localparam logic [RADIX_W-1:0] RADIX_AUTO   = 6'd0;
   localparam logic [RADIX_W-1:0] RADIX_OCT    = 6'd8;
   localparam logic [RADIX_W-1:0] RADIX_DEC    = 6'd10;
   localparam logic [RADIX_W-1:0] RADIX_HEX    = 6'd16;

   localparam logic [VALUE_W-1:0] U64_MAX     = {VALUE_W{1'b1}};
   localparam logic [VALUE_W-1:0] S64_MAX_ABS = {1'b0, {(VALUE_W-1){1'b1}}};
   localparam logic [VALUE_W-1:0] S64_MIN_ABS = {1'b1, {(VALUE_W-1){1'b0}}};

   typedef enum logic [STATUS_W-1:0] {
      STATUS_OK      = 2'd0,
      STATUS_RANGE   = 2'd1,
      STATUS_INVALID = 2'd2
   } status_type;

   typedef struct packed {
      logic [CH_W-1:0] ch;
      logic            start_of_string;
   } req_item_type;

   typedef struct packed {
      logic [VALUE_W-1:0]      result_value;
      logic [END_OFFSET_W-1:0] end_offset;
      status_type              status;
   } rsp_item_type;

   // handshake between the pipeline stages
   typedef struct packed {
      logic valid;
      logic ready;
   } stage_ctl_type;

endpackage

@@ hdl/stip_in_stage.sv @@
module stip_in_stage (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  stip_pkg::req_item_type req_item,
   output stip_pkg::stage_ctl_type in_ctl,
   input  logic                  step_fire,
   output stip_pkg::req_item_type item
);
   import stip_pkg::*;

   logic         valid_ff, valid_in;
   req_item_type item_ff, item_in;

   // slot frees when the core takes the held request
   assign req_ready = !valid_ff || step_fire;

   always_comb begin
      valid_in = valid_ff;
      item_in  = item_ff;
      if (req_ready) begin
         valid_in = req_valid;
         item_in  = req_item;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      item_ff <= item_in;
   end

   assign in_ctl.valid = valid_ff;
   assign in_ctl.ready = req_ready;
   assign item         = item_ff;

endmodule

@@ hdl/stip_core.sv @@
module stip_core (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           step_fire,
   input  stip_pkg::req_item_type         item,
   input  logic [stip_pkg::RADIX_W-1:0]   radix,
   input  logic                           signed_mode,
   output logic                           emit,
   output stip_pkg::rsp_item_type         result
);
   import stip_pkg::*;

   localparam int DIGIT_W = 7;
   localparam int PROD_W  = VALUE_W + RADIX_W;
   localparam logic [DIGIT_W-1:0] NO_DIGIT = 7'd99;
   localparam logic [OFFSET_BITS-1:0] OFFSET_MAX = {OFFSET_BITS{1'b1}};

   typedef enum logic [2:0] {
      PH_IDLE, PH_LEAD, PH_FIRST, PH_ZERO, PH_PREFIX, PH_DIGITS, PH_DONE
   } phase_type;

   phase_type              phase_ff, phase_in;
   logic [VALUE_W-1:0]     accum_ff, accum_in;
   logic                   neg_ff, neg_in;
   logic                   ovf_ff, ovf_in;
   logic                   seen_ff, seen_in;
   logic [RADIX_W-1:0]     arad_ff, arad_in;
   logic [OFFSET_BITS-1:0] count_ff, count_in;
   logic [OFFSET_BITS-1:0] zend_ff, zend_in;

   logic [OFFSET_BITS-1:0] pos;
   logic [OFFSET_BITS-1:0] fin_end;
   logic [DIGIT_W-1:0]     digit;
   logic                   handled;
   logic                   add;
   logic                   fin;
   logic                   is_ws;
   logic [RADIX_W-1:0]     mul_radix;
   logic [PROD_W-1:0]      prod;
   logic [VALUE_W-1:0]     limit;
   logic                   over;
   logic [VALUE_W-1:0]     fin_value;

   function automatic logic [DIGIT_W-1:0] digit_of(input logic [CH_W-1:0] c);
      logic [DIGIT_W-1:0] d;
      d = NO_DIGIT;
      if (c >= "0" && c <= "9")      d = DIGIT_W'(c - 8'h30);
      else if (c >= "a" && c <= "z") d = DIGIT_W'(c - 8'h61 + 8'd10);
      else if (c >= "A" && c <= "Z") d = DIGIT_W'(c - 8'h41 + 8'd10);
      return d;
   endfunction

   function automatic logic [OFFSET_BITS-1:0] sat_inc(input logic [OFFSET_BITS-1:0] v);
      return (v == OFFSET_MAX) ? OFFSET_MAX : v + 1'b1;
   endfunction

   assign digit = digit_of(item.ch);
   assign is_ws = (item.ch == 8'h20) || (item.ch >= 8'h09 && item.ch <= 8'h0d);

   // per-character parse step
   always_comb begin
      phase_in = phase_ff;
      accum_in = accum_ff;
      neg_in   = neg_ff;
      ovf_in   = ovf_ff;
      seen_in  = seen_ff;
      arad_in  = arad_ff;
      count_in = count_ff;
      zend_in  = zend_ff;
      pos      = count_ff;
      fin_end  = '0;
      handled  = 1'b0;
      add      = 1'b0;
      fin      = 1'b0;
      emit     = 1'b0;
      result.result_value = '0;
      result.end_offset   = '0;
      result.status       = STATUS_OK;

      // new string restarts everything
      if (item.start_of_string) begin
         accum_in = '0;
         neg_in   = 1'b0;
         ovf_in   = 1'b0;
         seen_in  = 1'b0;
         count_in = '0;
         zend_in  = '0;
         if (radix != RADIX_AUTO && (radix < RADIX_MIN || radix > RADIX_MAX)) begin
            phase_in      = PH_DONE;
            arad_in       = RADIX_AUTO;
            emit          = 1'b1;
            result.status = STATUS_INVALID;
            handled       = 1'b1;
         end else begin
            arad_in  = radix;
            phase_in = PH_LEAD;
         end
      end

      if (!handled && (phase_in == PH_LEAD || phase_in == PH_FIRST || phase_in == PH_ZERO ||
                       phase_in == PH_PREFIX || phase_in == PH_DIGITS)) begin
         pos      = count_in;
         count_in = sat_inc(count_in);

         // leading whitespace and sign
         if (phase_in == PH_LEAD) begin
            if (is_ws) begin
               handled = 1'b1;
            end else begin
               phase_in = PH_FIRST;
               if (item.ch == "+" || item.ch == "-") begin
                  neg_in  = (item.ch == "-");
                  handled = 1'b1;
               end
            end
         end

         // radix prefix detection
         if (!handled) begin
            case (phase_in)
               PH_FIRST: begin
                  if (item.ch == "0" && (arad_in == RADIX_AUTO || arad_in == RADIX_HEX)) begin
                     if (arad_in == RADIX_AUTO) arad_in = RADIX_OCT;
                     seen_in  = 1'b1;
                     zend_in  = sat_inc(pos);
                     phase_in = PH_ZERO;
                     handled  = 1'b1;
                  end else begin
                     if (arad_in == RADIX_AUTO) arad_in = RADIX_DEC;
                     phase_in = PH_DIGITS;
                  end
               end
               PH_ZERO: begin
                  if (item.ch == "x" || item.ch == "X") begin
                     phase_in = PH_PREFIX;
                     handled  = 1'b1;
                  end else begin
                     phase_in = PH_DIGITS;
                  end
               end
               PH_PREFIX: begin
                  handled = 1'b1;
                  if (digit < 7'd16) begin
                     arad_in  = RADIX_HEX;
                     add      = 1'b1;
                     phase_in = PH_DIGITS;
                  end else begin
                     fin     = 1'b1;
                     fin_end = zend_ff;
                  end
               end
               default: begin
               end
            endcase
         end

         // digit body
         if (!handled) begin
            if (digit < {1'b0, arad_in}) begin
               add = 1'b1;
            end else begin
               fin     = 1'b1;
               fin_end = pos;
            end
         end
      end

      // accumulate with overflow check against the live limit
      mul_radix = (arad_in == RADIX_AUTO) ? RADIX_DEC : arad_in;
      prod      = accum_in * mul_radix + PROD_W'(digit);
      if (!signed_mode)  limit = U64_MAX;
      else if (neg_in)   limit = S64_MIN_ABS;
      else               limit = S64_MAX_ABS;
      over = prod > {{RADIX_W{1'b0}}, limit};
      if (add) begin
         seen_in = 1'b1;
         if (over)         ovf_in   = 1'b1;
         else if (!ovf_in) accum_in = prod[VALUE_W-1:0];
      end

      // end of number: build the response
      if (ovf_in) begin
         if (signed_mode) fin_value = neg_in ? S64_MIN_ABS : S64_MAX_ABS;
         else             fin_value = U64_MAX;
      end else begin
         fin_value = neg_in ? (VALUE_W'(0) - accum_in) : accum_in;
      end
      if (fin) begin
         phase_in            = PH_DONE;
         emit                = 1'b1;
         result.result_value = fin_value;
         result.end_offset   = seen_in ? END_OFFSET_W'(fin_end) : '0;
         result.status       = ovf_in ? STATUS_RANGE : STATUS_OK;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE;
      end else if (step_fire) begin
         phase_ff <= phase_in;
      end
      if (step_fire) begin
         accum_ff <= accum_in;
         neg_ff   <= neg_in;
         ovf_ff   <= ovf_in;
         seen_ff  <= seen_in;
         arad_ff  <= arad_in;
         count_ff <= count_in;
         zend_ff  <= zend_in;
      end
   end

endmodule

@@ hdl/stip_out_stage.sv @@
module stip_out_stage (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   load,
   input  stip_pkg::rsp_item_type result,
   output stip_pkg::stage_ctl_type out_ctl,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output stip_pkg::rsp_item_type rsp_item
);
   import stip_pkg::*;

   logic         valid_ff, valid_in;
   rsp_item_type item_ff, item_in;
   logic         space;

   // the core may step when the slot is empty or is being drained
   assign space = !valid_ff || rsp_ready;

   always_comb begin
      valid_in = valid_ff && !rsp_ready;
      item_in  = item_ff;
      if (space && load) begin
         valid_in = 1'b1;
         item_in  = result;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      item_ff <= item_in;
   end

   assign out_ctl.valid = valid_ff;
   assign out_ctl.ready = space;
   assign rsp_valid     = valid_ff;
   assign rsp_item      = item_ff;

endmodule

@@ hdl/string_to_integer_parser.sv @@
// channel   | handshake          | payload
// ----------+--------------------+------------------------------------------------
// req       | req_valid/ready    | req_ch[7:0], req_start_of_string
// rsp       | rsp_valid/ready    | rsp_result_value[63:0], rsp_end_offset[15:0],
//           |                    | rsp_status[1:0]
// csr       | csr_we (no ready)  | csr_index[0], csr_wdata[5:0]
//
// one request per cycle sustained unless a response stalls; the request that
// ends the number passes the input register, then one parse step into the
// response register. The single 64x6 multiply-add per step sets the cycle.
// reset is synchronous active high: radix 10, signed mode, no string active.
// a stalled response holds the step; requests keep flowing while the
// response register is empty or being taken.
module string_to_integer_parser (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic [stip_pkg::CH_W-1:0]           req_ch,
   input  logic                                req_start_of_string,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic [stip_pkg::VALUE_W-1:0]        rsp_result_value,
   output logic [stip_pkg::END_OFFSET_W-1:0]   rsp_end_offset,
   output logic [stip_pkg::STATUS_W-1:0]       rsp_status,
   input  logic                                csr_we,
   input  logic [stip_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [stip_pkg::CSR_DATA_W-1:0]     csr_wdata
);
   import stip_pkg::*;

   logic [RADIX_W-1:0] radix_ff;
   logic               signed_mode_ff;
   req_item_type       req_item;
   req_item_type       item;
   stage_ctl_type      in_ctl;
   stage_ctl_type      out_ctl;
   logic               step_fire;
   logic               emit;
   rsp_item_type       result;
   rsp_item_type       rsp_item;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         radix_ff       <= RADIX_RESET;
         signed_mode_ff <= 1'b1;
      end else if (csr_we) begin
         case (csr_index)
            REG_RADIX:       radix_ff       <= csr_wdata;
            REG_SIGNED_MODE: signed_mode_ff <= csr_wdata[0];
            default: begin
            end
         endcase
      end
   end

   assign req_item.ch              = req_ch;
   assign req_item.start_of_string = req_start_of_string;

   // a held request steps when the response slot can take a result
   assign step_fire = in_ctl.valid && out_ctl.ready;

   stip_in_stage u_in_stage (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_item  (req_item),
      .in_ctl    (in_ctl),
      .step_fire (step_fire),
      .item      (item)
   );

   stip_core u_core (
      .clock       (clock),
      .reset       (reset),
      .step_fire   (step_fire),
      .item        (item),
      .radix       (radix_ff),
      .signed_mode (signed_mode_ff),
      .emit        (emit),
      .result      (result)
   );

   stip_out_stage u_out_stage (
      .clock     (clock),
      .reset     (reset),
      .load      (step_fire && emit),
      .result    (result),
      .out_ctl   (out_ctl),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_item  (rsp_item)
   );

   assign rsp_result_value = rsp_item.result_value;
   assign rsp_end_offset   = rsp_item.end_offset;
   assign rsp_status       = rsp_item.status;

endmodule

@@ hdl/stip_checker.sv @@
module stip_checker (
   input logic                                clock,
   input logic                                reset,
   input logic                                req_valid,
   input logic                                req_ready,
   input logic [stip_pkg::CH_W-1:0]           req_ch,
   input logic                                req_start_of_string,
   input logic                                rsp_valid,
   input logic                                rsp_ready,
   input logic [stip_pkg::VALUE_W-1:0]        rsp_result_value,
   input logic [stip_pkg::END_OFFSET_W-1:0]   rsp_end_offset,
   input logic [stip_pkg::STATUS_W-1:0]       rsp_status,
   input logic                                csr_we,
   input logic [stip_pkg::CSR_INDEX_W-1:0]    csr_index,
   input logic [stip_pkg::CSR_DATA_W-1:0]     csr_wdata
);
   import stip_pkg::*;

   // a stalled response keeps its payload
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_result_value) &&
         $stable(rsp_end_offset) && $stable(rsp_status))
      else $error("response changed while stalled");

   // bad radix reports nothing consumed and a zero value
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == STATUS_INVALID |-> rsp_result_value == '0 &&
         rsp_end_offset == '0)
      else $error("invalid radix response carries data");

   // out of range always saturates
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == STATUS_RANGE |->
         rsp_result_value == U64_MAX || rsp_result_value == S64_MAX_ABS ||
         rsp_result_value == S64_MIN_ABS)
      else $error("out of range response not saturated");

   // no digits means a zero value
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == STATUS_OK && rsp_end_offset == '0 |->
         rsp_result_value == '0)
      else $error("value without consumed digits");

endmodule

bind string_to_integer_parser stip_checker u_stip_checker (.*);
